// ----- sv/gdba_pkg.sv -----
// Shared types and constants for the bitmap block allocator.
// Used by the controller, the datapath and the top level.
`default_nettype none
package gdba_pkg;

    localparam int GROUP_BLOCKS     = 1024;
    localparam int MAX_GROUPS       = 16;
    localparam int MAP_WORDS        = 256;
    localparam int WIDX_W           = 8;
    localparam int GCNT_W           = 11;
    localparam int TCNT_W           = 15;
    localparam int ADDR_W           = 15;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_EXACT = 2'd1,
        OP_FREE  = 2'd2,
        OP_RANGE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_NEXT,
        S_GCHK,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic take;
        logic clear;
        logic adv;
        logic next_grp;
        logic fail;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic bad;
        logic empty;
        logic cnt_zero;
        logic found;
        logic grp_last;
        logic range_last;
        logic iter_done;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- sv/gdba_ctrl.sv -----
// Sequencer for the allocator: walks goal scan, group round robin, single-block requests and range frees.
// Depends on gdba_pkg; drives gdba_datapath through t_dp_cmd.
`default_nettype none
module gdba_ctrl
    import gdba_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy,
    output logic         o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.bad || i_sts.empty) begin
                    n_state = S_DONE;
                end else if (i_sts.op == OP_ALLOC && i_sts.cnt_zero) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                unique case (i_sts.op)
                    OP_ALLOC: begin
                        if (i_sts.found) begin
                            o_cmd.take = 1'b1;
                            n_state    = S_DONE;
                        end else if (i_sts.grp_last) begin
                            n_state = S_NEXT;
                        end else begin
                            o_cmd.adv = 1'b1;
                            n_state   = S_READ;
                        end
                    end
                    OP_EXACT: begin
                        o_cmd.take = i_sts.found;
                        n_state    = S_DONE;
                    end
                    OP_FREE, OP_RANGE: begin
                        o_cmd.clear = 1'b1;
                        if (i_sts.range_last) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.adv = 1'b1;
                            n_state   = S_READ;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_NEXT: begin
                if (i_sts.iter_done) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.next_grp = 1'b1;
                    n_state        = S_GCHK;
                end
            end
            S_GCHK: begin
                // skip groups whose free count is zero
                n_state = i_sts.cnt_zero ? S_NEXT : S_READ;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted but block not busy");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.take && o_cmd.clear))
        else $error("take and clear issued together");

    a_fail_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fail |-> (i_sts.op == OP_ALLOC))
        else $error("no-free status raised outside allocation");

endmodule
`default_nettype wire

// ----- sv/gdba_datapath.sv -----
// Bitmap memory, free counters, address registers and result registers.
// Depends on gdba_pkg; commanded by gdba_ctrl.
`default_nettype none
module gdba_datapath
    import gdba_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_dp_cmd       i_cmd,
    output t_dp_sts            o_sts,
    input  wire logic [1:0]    i_command,
    input  wire logic [14:0]   i_block_address,
    input  wire logic [14:0]   i_block_count,
    input  wire logic          i_dso,
    input  wire logic [4:0]    i_groups,
    input  wire logic          i_reload,
    output logic [14:0]        o_allocated_address,
    output logic [1:0]         o_status,
    output logic               o_was_free
);

    logic [63:0]          r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_valid;
    logic [63:0]          r_rdata;
    logic                 r_rvalid;
    logic [GCNT_W-1:0]    r_gcnt [MAX_GROUPS];
    logic [TCNT_W-1:0]    r_total;

    t_op                  r_op;
    logic                 r_bad;
    logic                 r_empty;
    logic [WIDX_W-1:0]    r_widx;
    logic [5:0]           r_lo;
    logic [13:0]          r_end;
    logic [4:0]           r_iter;
    logic [14:0]          r_alloc;
    t_status              r_status;
    logic                 r_was_free;

    // request decode
    logic        below;
    logic [14:0] rel15, relg, limit, end15, room;
    logic        bad;
    logic [13:0] end_sel;

    // word evaluation
    logic [63:0] word, msk, cand;
    logic [5:0]  hi, fbit;
    logic        found;
    logic [6:0]  nblk;
    logic [3:0]  grp, gnext;
    logic [4:0]  ginc;
    logic [11:0] gsum;
    logic [15:0] tsum;

    always_comb begin
        below = (i_block_address < {14'd0, i_dso});
        rel15 = i_block_address - {14'd0, i_dso};
        limit = {i_groups, 10'd0};
        relg  = below ? 15'd0 : rel15;
        room  = limit - rel15;
        end15 = rel15 + i_block_count - 15'd1;
        bad   = 1'b0;
        end_sel = '1;
        unique case (t_op'(i_command))
            OP_ALLOC: begin
                bad     = (relg >= limit);
                end_sel = '1;
            end
            OP_EXACT, OP_FREE: begin
                bad     = below || (rel15 >= limit);
                end_sel = rel15[13:0];
            end
            OP_RANGE: begin
                bad     = (i_block_count != 15'd0) &&
                          (below || (rel15 >= limit) || (i_block_count > room));
                end_sel = end15[13:0];
            end
            default: bad = 1'b1;
        endcase
    end

    always_comb begin
        word = r_rvalid ? r_rdata : 64'd0;
        hi   = (r_widx == r_end[13:6]) ? r_end[5:0] : 6'd63;
        for (int i = 0; i < 64; i++) begin
            msk[i] = (6'(i) >= r_lo) && (6'(i) <= hi);
        end
        cand  = ~word & msk;
        found = |cand;
        fbit  = '0;
        for (int i = 63; i >= 0; i--) begin
            if (cand[i]) fbit = 6'(i);
        end
        nblk  = {1'b0, hi} - {1'b0, r_lo} + 7'd1;
        grp   = r_widx[7:4];
        ginc  = {1'b0, grp} + 5'd1;
        gnext = (ginc == i_groups) ? 4'd0 : ginc[3:0];
        gsum  = {1'b0, r_gcnt[grp]} + {5'd0, nblk};
        tsum  = {1'b0, r_total} + {9'd0, nblk};
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.bad        = r_bad;
        o_sts.empty      = r_empty;
        o_sts.cnt_zero   = (r_gcnt[grp] == '0);
        o_sts.found      = found;
        o_sts.grp_last   = (r_widx[3:0] == 4'hF);
        o_sts.range_last = (r_widx == r_end[13:6]);
        o_sts.iter_done  = (r_iter == i_groups);
    end

    // bitmap storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_widx];
        end
        if (i_cmd.take) begin
            r_mem[r_widx] <= word | (64'd1 << fbit);
        end else if (i_cmd.clear) begin
            r_mem[r_widx] <= word & ~msk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_cmd.rd) r_rvalid <= r_valid[r_widx];
            if (i_cmd.take || i_cmd.clear) r_valid[r_widx] <= 1'b1;
        end
    end

    // free counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < MAX_GROUPS; g++) r_gcnt[g] <= GCNT_W'(GROUP_BLOCKS);
            r_total <= TCNT_W'(MAX_GROUPS * GROUP_BLOCKS);
        end else if (i_reload) begin
            for (int g = 0; g < MAX_GROUPS; g++) r_gcnt[g] <= GCNT_W'(GROUP_BLOCKS);
            r_total <= {i_groups, 10'd0};
        end else if (i_cmd.take) begin
            if (r_gcnt[grp] != '0) r_gcnt[grp] <= r_gcnt[grp] - 11'd1;
            if (r_total != '0) r_total <= r_total - 15'd1;
        end else if (i_cmd.clear) begin
            // saturate on the sum: same as stepping one block at a time
            r_gcnt[grp] <= gsum[11] ? '1 : gsum[10:0];
            r_total     <= tsum[15] ? '1 : tsum[14:0];
        end
    end

    // request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_op'(i_command);
            r_bad      <= bad;
            r_empty    <= (t_op'(i_command) == OP_RANGE) && (i_block_count == 15'd0);
            r_widx     <= relg[13:6];
            r_lo       <= relg[5:0];
            r_end      <= end_sel;
            r_iter     <= '0;
            r_alloc    <= '0;
            r_status   <= bad ? STS_RANGE : STS_OK;
            r_was_free <= 1'b0;
        end else begin
            if (i_cmd.adv) begin
                r_widx <= r_widx + 8'd1;
                r_lo   <= '0;
            end
            if (i_cmd.next_grp) begin
                r_widx <= {gnext, 4'd0};
                r_lo   <= '0;
                r_iter <= r_iter + 5'd1;
            end
            if (i_cmd.take) begin
                r_alloc    <= {1'b0, r_widx, fbit} + {14'd0, i_dso};
                r_was_free <= (r_op == OP_EXACT);
            end
            if (i_cmd.fail) begin
                r_status <= STS_FULL;
            end
        end
    end

    assign o_allocated_address = r_alloc;
    assign o_status            = r_status;
    assign o_was_free          = r_was_free;

endmodule
`default_nettype wire

// ----- sv/goal_directed_bitmap_block_allocator_core.sv -----
// Top level of the goal-directed bitmap block allocator: configuration port and wiring.
// Depends on gdba_pkg, gdba_ctrl and gdba_datapath.
//
// One request at a time: o_busy rises after i_start and o_done pulses for one cycle
// with the result. Each bitmap word is read from memory in S_READ, then evaluated and
// written back in S_EVAL. An allocation scans the goal group, then visits the other
// groups in round robin, and reports full when no group yields a block; there are up
// to 16 groups of 16 words. A single-block free or try touches one word; a range free
// reads and clears every word it touches. Results cannot be held off. Writing
// groups_in_use reloads all free counts in the cycle after the write.
`default_nettype none
module goal_directed_bitmap_block_allocator_core
    import gdba_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [14:0] i_block_address,
    input  wire logic [14:0] i_block_count,
    output logic             o_done,
    output logic [14:0]      o_allocated_address,
    output logic [1:0]       o_status,
    output logic             o_was_free,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic       r_dso;
    logic [4:0] r_groups;
    logic [4:0] n_groups;
    logic       r_reload;
    logic       wr_en;
    logic       reload;
    t_dp_cmd    cmd;
    t_dp_sts    sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign reload = wr_en && paddr[2];

    always_comb begin
        // clamp group count into 1..MAX_GROUPS
        priority if (pwdata[4:0] == 5'd0) begin
            n_groups = 5'd1;
        end else if (pwdata[4:0] > 5'(MAX_GROUPS)) begin
            n_groups = 5'(MAX_GROUPS);
        end else begin
            n_groups = pwdata[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dso    <= 1'b0;
            r_groups <= 5'(MAX_GROUPS);
            r_reload <= 1'b0;
        end else begin
            // reload in the cycle after the write so the total sees the new group count
            r_reload <= reload;
            if (wr_en) begin
                if (paddr[2]) r_groups <= n_groups;
                else          r_dso    <= pwdata[0];
            end
        end
    end

    assign prdata = paddr[2] ? {27'd0, r_groups} : {31'd0, r_dso};

    gdba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    gdba_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_command           (i_command),
        .i_block_address     (i_block_address),
        .i_block_count       (i_block_count),
        .i_dso               (r_dso),
        .i_groups            (r_groups),
        .i_reload            (r_reload),
        .o_allocated_address (o_allocated_address),
        .o_status            (o_status),
        .o_was_free          (o_was_free)
    );

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for goal_directed_bitmap_block_allocator_core.
// Needs gdba_pkg and the block's RTL; predicts results from its own copy of the bitmap, or takes them from typed rows.
`default_nettype none
module tb;
    import gdba_pkg::*;

    typedef struct {
        logic [14:0] addr;
        t_status     st;
        logic        wf;
    } t_alloc_result;

    // One directed row: either a register write or a request, with an optional typed result
    typedef struct {
        bit          is_reg;
        logic [2:0]  reg_addr;
        int          reg_val;
        t_op         cmd;
        int          addr;
        int          cnt;
        bit          typed;
        int          x_addr;
        t_status     x_st;
        bit          x_wf;
    } t_row;

    typedef struct {
        bit            typed;
        t_alloc_result res;
    } t_typed;

    localparam logic [2:0] REG_START  = 3'd0;
    localparam logic [2:0] REG_GROUPS = 3'd4;
    localparam int         GRP_MAX    = 2 * GROUP_BLOCKS - 1;
    localparam int         TOT_MAX    = 2 * MAX_GROUPS * GROUP_BLOCKS - 1;
    localparam int         STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_command = '0;
    logic [14:0] i_block_address = '0;
    logic [14:0] i_block_count = '0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_busy, o_done, o_was_free, pready;
    logic [14:0] o_allocated_address;
    logic [1:0]  o_status;
    logic [31:0] prdata;

    goal_directed_bitmap_block_allocator_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    logic [63:0] used_map [MAP_WORDS];
    int          grp_free [MAX_GROUPS];
    int          tot_free;
    int          start_ofs;
    int          n_groups;

    t_alloc_result pending_q [$];
    t_typed        typed_q [$];
    int            n_errors = 0;
    int            idle_cycles = 0;
    bit            timed_out = 1'b0;

    function automatic bit blk_used(int b);
        if ((b >> 6) >= MAP_WORDS) return 1'b1;
        return used_map[b >> 6][b & 63];
    endfunction

    function automatic void reload_counts();
        for (int g = 0; g < MAX_GROUPS; g++) grp_free[g] = GROUP_BLOCKS;
        tot_free = n_groups * GROUP_BLOCKS;
    endfunction

    function automatic void take_blk(int r);
        int g;
        g = r / GROUP_BLOCKS;
        if ((r >> 6) < MAP_WORDS) used_map[r >> 6][r & 63] = 1'b1;
        if (g < MAX_GROUPS && grp_free[g] > 0) grp_free[g]--;
        if (tot_free > 0) tot_free--;
    endfunction

    function automatic void give_blk(int r);
        int g;
        g = r / GROUP_BLOCKS;
        if ((r >> 6) < MAP_WORDS) used_map[r >> 6][r & 63] = 1'b0;
        if (g < MAX_GROUPS && grp_free[g] < GRP_MAX) grp_free[g]++;
        if (tot_free < TOT_MAX) tot_free++;
    endfunction

    function automatic int first_clear(int g, int from);
        for (int i = from; i < GROUP_BLOCKS; i++)
            if (!blk_used(g * GROUP_BLOCKS + i)) return i;
        return -1;
    endfunction

    function automatic t_alloc_result allocate_step(t_op cmd, int addr, int cnt);
        t_alloc_result res;
        int limit, rel, gg, hit, hg, g;
        res = '{addr: '0, st: STS_OK, wf: 1'b0};
        limit = n_groups * GROUP_BLOCKS;
        case (cmd)
            OP_ALLOC: begin
                rel = (addr >= start_ofs) ? addr - start_ofs : 0;
                if (rel >= limit) begin
                    res.st = STS_RANGE;
                end else begin
                    gg = rel / GROUP_BLOCKS;
                    hit = -1;
                    hg = gg;
                    if (grp_free[gg] != 0) hit = first_clear(gg, rel % GROUP_BLOCKS);
                    // round robin over the other groups, goal group last
                    for (int i = 1; hit < 0 && i <= n_groups; i++) begin
                        g = (gg + i) % n_groups;
                        if (grp_free[g] != 0) begin
                            hit = first_clear(g, 0);
                            hg = g;
                        end
                    end
                    if (hit < 0) begin
                        res.st = STS_FULL;
                    end else begin
                        take_blk(hg * GROUP_BLOCKS + hit);
                        res.addr = 15'(hg * GROUP_BLOCKS + hit + start_ofs);
                    end
                end
            end
            OP_EXACT, OP_FREE: begin
                if (addr < start_ofs || addr - start_ofs >= limit) begin
                    res.st = STS_RANGE;
                end else if (cmd == OP_FREE) begin
                    give_blk(addr - start_ofs);
                end else if (!blk_used(addr - start_ofs)) begin
                    take_blk(addr - start_ofs);
                    res.wf = 1'b1;
                    res.addr = 15'(addr);
                end
            end
            default: begin
                if (cnt != 0) begin
                    rel = addr - start_ofs;
                    if (addr < start_ofs || rel >= limit || cnt > limit - rel)
                        res.st = STS_RANGE;
                    else
                        for (int i = 0; i < cnt; i++) give_blk(rel + i);
                end
            end
        endcase
        return res;
    endfunction

    // Check results first, then predict the request taken at the same edge
    always @(posedge i_clk) begin
        t_alloc_result x;
        t_alloc_result p;
        t_typed t;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_q.size() == 0) begin
                    $error("result with nothing outstanding");
                    n_errors++;
                end else begin
                    x = pending_q.pop_front();
                    if (o_allocated_address !== x.addr) begin
                        $error("allocated_address expected %0d got %0d", x.addr,
                               o_allocated_address);
                        n_errors++;
                    end
                    if (o_status !== x.st) begin
                        $error("status expected %0d got %0d", x.st, o_status);
                        n_errors++;
                    end
                    if (o_was_free !== x.wf) begin
                        $error("was_free expected %0d got %0d", x.wf, o_was_free);
                        n_errors++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                p = allocate_step(t_op'(i_command), int'(i_block_address),
                                  int'(i_block_count));
                t = typed_q.pop_front();
                pending_q.push_back(t.typed ? t.res : p);
            end
            if ((i_start && !o_busy) || o_done) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("goal_directed_bitmap_block_allocator_core verification failed");
                $finish;
            end
        end
    end

    bit start_held = 1'b0;

    task automatic send_request(t_op cmd, int addr, int cnt, int idle_pct,
                                bit typed = 1'b0, t_alloc_result tres = '{'0, STS_OK, 1'b0});
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0 && start_held) begin
            i_start <= 1'b0;
            start_held = 1'b0;
        end
        repeat (gap) @(posedge i_clk);
        typed_q.push_back('{typed: typed, res: tres});
        i_start         <= 1'b1;
        i_command       <= cmd;
        i_block_address <= 15'(addr);
        i_block_count   <= 15'(cnt);
        start_held = 1'b1;
        // hold until taken
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic drain();
        if (start_held) begin
            i_start <= 1'b0;
            start_held = 1'b0;
        end
        wait (pending_q.size() == 0 && typed_q.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] a, int v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (a == REG_START) begin
            start_ofs = v & 1;
        end else begin
            n_groups = v & 31;
            if (n_groups == 0) n_groups = 1;
            if (n_groups > MAX_GROUPS) n_groups = MAX_GROUPS;
            reload_counts();
        end
        @(posedge i_clk);
    endtask

    task automatic random_burst(int n, int idle_pct);
        int limit, sel, addr, cnt;
        t_op cmd;
        for (int k = 0; k < n; k++) begin
            limit = n_groups * GROUP_BLOCKS;
            sel = $urandom_range(99);
            cmd = (sel < 50) ? OP_ALLOC : (sel < 70) ? OP_EXACT : (sel < 85) ? OP_FREE : OP_RANGE;
            if ($urandom_range(9) == 0) addr = $urandom_range(32767);
            else addr = $urandom_range(limit - 1 + start_ofs);
            sel = $urandom_range(19);
            if (sel == 0) cnt = 0;
            else if (sel == 1) cnt = $urandom_range(32767);
            else if (sel == 2) cnt = $urandom_range(limit);
            else cnt = $urandom_range(1, 64);
            send_request(cmd, addr, cnt, idle_pct);
        end
        drain();
    endtask

    t_row dir_rows [$] = '{
        '{0, REG_START, 0, OP_ALLOC, 0,     0,     1, 0,     STS_OK,    0},
        '{0, REG_START, 0, OP_ALLOC, 0,     0,     1, 1,     STS_OK,    0},
        '{0, REG_START, 0, OP_EXACT, 0,     0,     1, 0,     STS_OK,    0},
        '{0, REG_START, 0, OP_EXACT, 16383, 0,     1, 16383, STS_OK,    1},
        '{0, REG_START, 0, OP_EXACT, 16384, 0,     1, 0,     STS_RANGE, 0},
        '{0, REG_START, 0, OP_FREE,  2,     0,     1, 0,     STS_OK,    0},
        '{0, REG_START, 0, OP_FREE,  32767, 0,     1, 0,     STS_RANGE, 0},
        '{0, REG_START, 0, OP_RANGE, 0,     0,     1, 0,     STS_OK,    0},
        '{0, REG_START, 0, OP_RANGE, 16383, 2,     1, 0,     STS_RANGE, 0},
        '{0, REG_START, 0, OP_RANGE, 0,     32767, 1, 0,     STS_RANGE, 0},
        '{0, REG_START, 0, OP_RANGE, 0,     16384, 1, 0,     STS_OK,    0},
        '{0, REG_START, 0, OP_ALLOC, 16384, 0,     1, 0,     STS_RANGE, 0},
        '{0, REG_START, 0, OP_ALLOC, 32767, 0,     1, 0,     STS_RANGE, 0},
        '{0, REG_START, 0, OP_ALLOC, 63,    0,     0, 0,     STS_OK,    0},
        '{0, REG_START, 0, OP_ALLOC, 63,    0,     0, 0,     STS_OK,    0},
        '{0, REG_START, 0, OP_ALLOC, 1023,  0,     0, 0,     STS_OK,    0},
        '{1, REG_START, 1, OP_ALLOC, 0,     0,     0, 0,     STS_OK,    0},
        '{1, REG_GROUPS, 2, OP_ALLOC, 0,    0,     0, 0,     STS_OK,    0},
        '{0, REG_START, 0, OP_ALLOC, 0,     0,     0, 0,     STS_OK,    0},
        '{0, REG_START, 0, OP_EXACT, 0,     0,     1, 0,     STS_RANGE, 0},
        '{0, REG_START, 0, OP_FREE,  0,     0,     1, 0,     STS_RANGE, 0},
        '{0, REG_START, 0, OP_RANGE, 0,     1,     1, 0,     STS_RANGE, 0},
        '{0, REG_START, 0, OP_EXACT, 2048,  0,     0, 0,     STS_OK,    0},
        '{0, REG_START, 0, OP_EXACT, 2049,  0,     1, 0,     STS_RANGE, 0},
        '{0, REG_START, 0, OP_RANGE, 1,     2048,  0, 0,     STS_OK,    0}
    };

    initial begin
        t_row r;
        for (int w = 0; w < MAP_WORDS; w++) used_map[w] = '0;
        start_ofs = 0;
        n_groups = MAX_GROUPS;
        reload_counts();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            if (r.is_reg) begin
                drain();
                reg_write(r.reg_addr, r.reg_val);
            end else begin
                send_request(r.cmd, r.addr, r.cnt, 0, r.typed,
                             '{15'(r.x_addr), r.x_st, r.x_wf});
            end
        end
        drain();

        reg_write(REG_GROUPS, 5);
        random_burst(120, 37);
        reg_write(REG_START, 0);
        reg_write(REG_GROUPS, 16);
        random_burst(120, 80);
        reg_write(REG_GROUPS, 31);
        random_burst(120, 0);

        // group count written as zero runs with a single group
        reg_write(REG_START, 1);
        reg_write(REG_GROUPS, 0);
        random_burst(20, 0);
        reg_write(REG_GROUPS, 16);
        random_burst(20, 0);

        if (n_errors == 0)
            $display("goal_directed_bitmap_block_allocator_core verification clean");
        else
            $display("goal_directed_bitmap_block_allocator_core verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/gdba_pkg.sv
sv/gdba_ctrl.sv
sv/gdba_datapath.sv
sv/goal_directed_bitmap_block_allocator_core.sv
test/tb.sv
